// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the receiver RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bsfr_pkg.sv
// Package for the byte-stuffed frame receiver: item types, codes, command structs
// and the CRC-16 byte update. No dependencies.
package bsfr_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
  localparam logic [15:0] CRC_MSB   = 16'h8000;

  // Byte counter width; holds INFO_BYTES + 5 for the largest supported payload.
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] ADDR_RESET  = 8'd0;
  localparam logic [7:0] CODE_A_RESET = 8'd1;
  localparam logic [7:0] CODE_B_RESET = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_ADDRESS = 2'd0,
    CFG_COMMAND_CODE_A   = 2'd1,
    CFG_COMMAND_CODE_B   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FS_OK        = 3'd0,
    FS_BAD_LEN   = 3'd1,
    FS_BAD_ADDR  = 3'd2,
    FS_BAD_CMD   = 3'd3,
    FS_BAD_CHECK = 3'd4
  } frame_status_t;

  typedef enum logic [1:0] {
    CS_RECV,
    CS_CLOSE,
    CS_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] frame_address;
    logic [7:0] frame_command;
    logic [2:0] frame_status;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic in_ready;
    logic byte_en;
    logic ram_rd;
    logic rd_first;
    logic advance;
    logic load_status;
    logic load_payload;
    logic rearm;
  } dp_cmd_t;

  typedef struct packed {
    logic close_flag;
    logic frame_ok;
    logic last_idx;
    logic out_free;
  } dp_sts_t;

  // One byte into the CRC-16 register, MSB first.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/bsfr_stream_if.sv
// Valid/ready stream interface used for the byte input and the result output.
// The payload type is a parameter; no other dependencies.
interface bsfr_stream_if #(
  parameter type item_t = logic [7:0]
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/byte_stuffed_frame_receiver.sv
// Byte-stuffed frame receiver with CRC-16 check, top level.
// Throughput: one link byte per cycle while a frame is being received.
// At a closing flag the input stalls: a failure status is loaded into the output register
// once it is free, and a good frame's payload streams 1 byte per cycle out of the
// payload RAM port while the sink applies no back-pressure.
// Reset is synchronous and active low; it restores the register defaults and rearms.
`include "assert_macros.svh"

module byte_stuffed_frame_receiver import bsfr_pkg::*; #(
  parameter int INFO_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]           cfg_wdata,
  bsfr_stream_if.sink          in_ch,
  bsfr_stream_if.source        out_ch
);

  // The controller decides when a byte is taken and when results are released; the
  // datapath holds every stored field, the CRC, the payload RAM and the output register.
  // The output register lets the next frame start arriving while the final result of
  // the previous one still waits for the sink.
  dp_cmd_t   cmd;
  dp_sts_t   sts;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;

  // Terms used by the checks at the end of the module.
  logic      fail_shown;
  logic      fail_shape_ok;
  logic      run_open;
  logic      result_load;
  logic      close_taken;

  assign in_item     = in_ch.data;
  assign in_ch.ready = cmd.in_ready;

  bsfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsfr_dp #(
    .INFO_BYTES (INFO_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_item),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_data  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  assign fail_shown    = out_ch.valid && (out_item.frame_status != FS_OK);
  assign fail_shape_ok = out_item.last_of_run && (out_item.payload_byte == 8'h00);
  assign run_open      = out_ch.valid && !out_item.last_of_run;
  assign result_load   = cmd.load_status || cmd.load_payload;
  assign close_taken   = in_ch.valid && in_ch.ready && sts.close_flag;

  // A failure status is always a single result with a zero payload byte.
  `ASSERT_IMPL(a_fail_is_single, fail_shown, fail_shape_ok, "failure result not single")

  // While a payload run is still being released no link byte is taken.
  `ASSERT_IMPL(a_run_blocks_input, run_open, !in_ch.ready, "input taken during a payload run")

  // Results are only loaded when the controller is not taking bytes.
  `ASSERT_IMPL(a_load_excl_intake, result_load, !cmd.byte_en, "load overlaps intake")

  // A closing flag taken from the link stops intake on the next cycle.
  `ASSERT_NEXT(a_close_stalls, close_taken, !in_ch.ready, "intake after a closing flag")

endmodule

// File: hw/rtl/bsfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/bsfr_ctrl.sv
// Controller state machine: byte intake, frame close decision and result release.
// Depends on bsfr_pkg.
module bsfr_ctrl import bsfr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      CS_RECV: begin
        cmd.in_ready = 1'b1;
        cmd.byte_en  = in_valid;
        if (in_valid && sts.close_flag) begin
          state_nxt = CS_CLOSE;
        end
      end
      CS_CLOSE: begin
        if (!sts.frame_ok) begin
          if (sts.out_free) begin
            cmd.load_status = 1'b1;
            cmd.rearm       = 1'b1;
            state_nxt       = CS_RECV;
          end
        end else begin
          cmd.ram_rd   = 1'b1;
          cmd.rd_first = 1'b1;
          state_nxt    = CS_LOAD;
        end
      end
      CS_LOAD: begin
        if (sts.out_free) begin
          cmd.load_payload = 1'b1;
          if (sts.last_idx) begin
            cmd.rearm = 1'b1;
            state_nxt = CS_RECV;
          end else begin
            cmd.advance = 1'b1;
            cmd.ram_rd  = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = CS_RECV;
      end
    endcase
  end

endmodule

// File: hw/rtl/bsfr_dp.sv
// Datapath: unstuffing, field capture, CRC-16, frame checks, payload RAM and
// the output register. Depends on bsfr_pkg and bsfr_ram.
module bsfr_dp import bsfr_pkg::*; #(
  parameter int INFO_BYTES = 16,
  localparam int IDX_W = (INFO_BYTES > 1) ? $clog2(INFO_BYTES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]           cfg_wdata,
  input  in_item_t             in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts
);

  localparam logic [CNT_W-1:0] CNT_CHK1 = CNT_W'(INFO_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_CHK2 = CNT_W'(INFO_BYTES + 3);
  localparam logic [CNT_W-1:0] CNT_LEN  = CNT_W'(INFO_BYTES + 4);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(INFO_BYTES + 5);
  localparam logic [IDX_W-1:0] LAST_K   = IDX_W'(INFO_BYTES - 1);

  logic [7:0]       exp_addr_r, code_a_r, code_b_r;
  logic             in_frame_r, esc_r;
  logic [CNT_W-1:0] count_r;
  logic [7:0]       addr_r, command_r, chk1_r, chk2_r;
  logic [15:0]      crc_r;
  logic [IDX_W-1:0] k_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic [7:0]       rx, data_byte;
  logic             is_esc, is_flag, is_data, take_data;
  logic [15:0]      crc_fin;
  frame_status_t    status;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_rdata;

  assign rx        = in_data.rx_byte;
  assign data_byte = esc_r ? (rx ^ ESC_XOR) : rx;
  assign is_esc    = !esc_r && (rx == ESC_BYTE);
  assign is_flag   = !esc_r && (rx == FLAG_BYTE);
  assign is_data   = !is_esc && !is_flag;
  assign take_data = cmd.byte_en && is_data && in_frame_r;

  assign crc_fin = crc_r ^ CRC_XOROUT;

  always_comb begin
    if (count_r != CNT_LEN) begin
      status = FS_BAD_LEN;
    end else if (addr_r != exp_addr_r) begin
      status = FS_BAD_ADDR;
    end else if ((command_r != code_a_r) && (command_r != code_b_r)) begin
      status = FS_BAD_CMD;
    end else if ((chk1_r != crc_fin[7:0]) || (chk2_r != crc_fin[15:8])) begin
      status = FS_BAD_CHECK;
    end else begin
      status = FS_OK;
    end
  end

  assign sts.close_flag = is_flag && in_frame_r;
  assign sts.frame_ok   = (status == FS_OK);
  assign sts.last_idx   = (k_r == LAST_K);
  assign sts.out_free   = !out_valid_r || out_ready;

  // Payload bytes sit at counts 2 .. INFO_BYTES+1.
  assign ram_we    = take_data && (count_r >= CNT_W'(2)) && (count_r < CNT_CHK1);
  assign ram_waddr = IDX_W'(count_r - CNT_W'(2));
  assign ram_raddr = cmd.rd_first ? '0 : IDX_W'(k_r + 1'b1);

  bsfr_ram #(
    .WIDTH (8),
    .DEPTH (INFO_BYTES)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (data_byte),
    .re    (cmd.ram_rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r  <= ADDR_RESET;
      code_a_r    <= CODE_A_RESET;
      code_b_r    <= CODE_B_RESET;
      in_frame_r  <= 1'b0;
      esc_r       <= 1'b0;
      count_r     <= '0;
      addr_r      <= '0;
      command_r   <= '0;
      chk1_r      <= '0;
      chk2_r      <= '0;
      crc_r       <= CRC_INIT;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_EXPECTED_ADDRESS: exp_addr_r <= cfg_wdata;
          CFG_COMMAND_CODE_A:   code_a_r   <= cfg_wdata;
          CFG_COMMAND_CODE_B:   code_b_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end

      if (cmd.rearm) begin
        in_frame_r <= 1'b0;
        esc_r      <= 1'b0;
        count_r    <= '0;
        addr_r     <= '0;
        command_r  <= '0;
        chk1_r     <= '0;
        chk2_r     <= '0;
        crc_r      <= CRC_INIT;
      end else if (cmd.byte_en) begin
        esc_r <= is_esc;
        if (is_flag && !in_frame_r) begin
          in_frame_r <= 1'b1;
          count_r    <= '0;
        end
        if (take_data) begin
          if (count_r == CNT_W'(0)) begin
            addr_r <= data_byte;
          end else if (count_r == CNT_W'(1)) begin
            command_r <= data_byte;
          end else if (count_r == CNT_CHK1) begin
            chk1_r <= data_byte;
          end else if (count_r == CNT_CHK2) begin
            chk2_r <= data_byte;
          end
          if (count_r < CNT_CHK1) begin
            crc_r <= crc16_update(crc_r, data_byte);
          end
          if (count_r < CNT_MAX) begin
            count_r <= count_r + 1'b1;
          end
        end
      end

      if (cmd.rd_first) begin
        k_r <= '0;
      end else if (cmd.advance) begin
        k_r <= k_r + 1'b1;
      end

      if (cmd.load_status || cmd.load_payload) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      out_r.payload_byte  <= '0;
      out_r.frame_address <= addr_r;
      out_r.frame_command <= command_r;
      out_r.frame_status  <= status;
      out_r.last_of_run   <= 1'b1;
    end else if (cmd.load_payload) begin
      out_r.payload_byte  <= ram_rdata;
      out_r.frame_address <= addr_r;
      out_r.frame_command <= command_r;
      out_r.frame_status  <= FS_OK;
      out_r.last_of_run   <= (k_r == LAST_K);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: tb/sv/byte_stuffed_frame_receiver_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for byte_stuffed_frame_receiver: link bytes in, frame results out.
// Depends on bsfr_pkg, the bsfr_stream_if interface and the receiver RTL; nothing else.

module byte_stuffed_frame_receiver_tb;
  import bsfr_pkg::*;

  localparam int INFO_BYTES     = 16;
  // Data bytes of a well-formed frame: address, command, payload and two check bytes.
  localparam int FRAME_LEN      = INFO_BYTES + 4;
  // The byte counter stops here on an overlong frame.
  localparam int COUNT_CAP      = INFO_BYTES + 5;
  // Wait at the end of a phase, after all expected results have been accepted.
  localparam int DRAIN_CYCLES   = INFO_BYTES + 10;
  localparam int HOLD_CYCLES    = 400;
  // The longest legal stretch without any accepted request is the receiver hold above.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PCT       = 9;
  localparam int PHASE_BYTES    = 12;

  typedef enum {FR_GOOD, FR_BAD_CHECK, FR_SHORT, FR_LONG, FR_NOISE} frame_kind_t;

  // One row of the directed plan. For short frames extent is the number of data bytes
  // kept, for long frames the number of extra bytes after the check bytes.
  typedef struct {
    frame_kind_t kind;
    int          extent;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [7:0]  fill;
    logic [7:0]  step;
    int          esc_pct;
    bit          typed;
    out_item_t   want;
  } frame_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [7:0]           cfg_wdata;

  bsfr_stream_if #(.item_t(in_item_t))  in_ch ();
  bsfr_stream_if #(.item_t(out_item_t)) out_ch ();

  byte_stuffed_frame_receiver #(
    .INFO_BYTES(INFO_BYTES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Predictor copy of the configuration registers.
  logic [7:0] cfg_exp_addr;
  logic [7:0] cfg_code_a;
  logic [7:0] cfg_code_b;

  // Predictor copy of the deframer state.
  bit               rx_in_frame;
  bit               rx_escape;
  logic [CNT_W-1:0] rx_count;
  logic [7:0]       rx_addr;
  logic [7:0]       rx_cmd;
  logic [7:0]       rx_check_lo;
  logic [7:0]       rx_check_hi;
  logic [7:0]       rx_payload [INFO_BYTES];
  logic [15:0]      rx_crc;

  // Results the block still owes, oldest first.
  out_item_t results_due [$];
  // A directed row may type its result in; the next closing flag then uses it.
  bit        typed_due;
  out_item_t typed_result;

  logic [7:0] frame_payload [INFO_BYTES];
  int         link_bytes_sent;
  int         mismatches;
  int         quiet_cycles;
  bit         steady;
  bit         hold_token;

  // Directed plan, run with the reset configuration: address 0, commands 1 and 2.
  // Failure statuses are typed in; good frames are left to the predictor.
  frame_row_t plan [13] = '{
    // Empty frame: two flags in a row.
    '{FR_SHORT, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b1,
      '{8'h00, 8'h00, 8'h00, FS_BAD_LEN, 1'b1}},
    // Frame that stops after the command byte.
    '{FR_SHORT, 2, 8'h00, 8'h01, 8'h00, 8'h00, 0, 1'b1,
      '{8'h00, 8'h00, 8'h01, FS_BAD_LEN, 1'b1}},
    // Payload made of flag values, all of them escaped on the link.
    '{FR_GOOD, 0, 8'h00, 8'h01, 8'h7E, 8'h00, 0, 1'b0, '0},
    // Payload made of escape values.
    '{FR_GOOD, 0, 8'h00, 8'h02, 8'h7D, 8'h00, 0, 1'b0, '0},
    // Payload runs down from 0x00 through 0xFF, 0xFE and so on.
    '{FR_GOOD, 0, 8'h00, 8'h01, 8'h00, 8'hFF, 0, 1'b0, '0},
    // Every data byte escaped, even ordinary ones.
    '{FR_GOOD, 0, 8'h00, 8'h02, 8'h80, 8'h11, 100, 1'b0, '0},
    '{FR_GOOD, 0, 8'hFF, 8'h01, 8'h12, 8'h07, 0, 1'b1,
      '{8'h00, 8'hFF, 8'h01, FS_BAD_ADDR, 1'b1}},
    '{FR_GOOD, 0, 8'h00, 8'hFF, 8'h34, 8'h05, 0, 1'b1,
      '{8'h00, 8'h00, 8'hFF, FS_BAD_CMD, 1'b1}},
    '{FR_GOOD, 0, 8'h00, 8'h00, 8'h56, 8'h03, 0, 1'b1,
      '{8'h00, 8'h00, 8'h00, FS_BAD_CMD, 1'b1}},
    '{FR_BAD_CHECK, 0, 8'h00, 8'h02, 8'h9A, 8'h01, 0, 1'b1,
      '{8'h00, 8'h00, 8'h02, FS_BAD_CHECK, 1'b1}},
    // Overlong frame: the count saturates and the close reports bad length.
    '{FR_LONG, 4, 8'h00, 8'h01, 8'hC3, 8'h09, 0, 1'b1,
      '{8'h00, 8'h00, 8'h01, FS_BAD_LEN, 1'b1}},
    // Outside a frame an escape swallows a flag; the following bytes are dropped.
    '{FR_NOISE, 0, 8'hA5, 8'h5A, 8'h00, 8'h00, 0, 1'b0, '0},
    // A clean frame right after the noise shows that it left nothing behind.
    '{FR_GOOD, 0, 8'h00, 8'h01, 8'h01, 8'h01, 0, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bit-serial CRC-16, MSB first: each data bit is folded into the top of the register.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic void rearm_deframer();
    rx_in_frame = 1'b0;
    rx_escape   = 1'b0;
    rx_count    = '0;
    rx_addr     = 8'h00;
    rx_cmd      = 8'h00;
    rx_check_lo = 8'h00;
    rx_check_hi = 8'h00;
    rx_crc      = CRC_INIT;
    for (int k = 0; k < INFO_BYTES; k++) begin
      rx_payload[k] = 8'h00;
    end
  endfunction

  // Closing flag: the checks run in the order length, address, command, check bytes.
  function automatic void judge_frame();
    frame_status_t st;
    logic [15:0]   fcs;
    out_item_t     r;
    fcs = rx_crc ^ CRC_XOROUT;
    if (rx_count != FRAME_LEN) begin
      st = FS_BAD_LEN;
    end else if (rx_addr != cfg_exp_addr) begin
      st = FS_BAD_ADDR;
    end else if (rx_cmd != cfg_code_a && rx_cmd != cfg_code_b) begin
      st = FS_BAD_CMD;
    end else if (rx_check_lo != fcs[7:0] || rx_check_hi != fcs[15:8]) begin
      st = FS_BAD_CHECK;
    end else begin
      st = FS_OK;
    end
    if (typed_due) begin
      results_due.push_back(typed_result);
      typed_due = 1'b0;
    end else if (st != FS_OK) begin
      r = '{8'h00, rx_addr, rx_cmd, st, 1'b1};
      results_due.push_back(r);
    end else begin
      for (int k = 0; k < INFO_BYTES; k++) begin
        r = '{rx_payload[k], rx_addr, rx_cmd, FS_OK, k == INFO_BYTES - 1};
        results_due.push_back(r);
      end
    end
    rearm_deframer();
  endfunction

  // Advances the predictor by one accepted link byte.
  function automatic void absorb_link_byte(input logic [7:0] raw);
    logic [7:0] b;
    b = raw;
    if (rx_escape) begin
      b = raw ^ ESC_XOR;
      rx_escape = 1'b0;
    end else if (raw == ESC_BYTE) begin
      rx_escape = 1'b1;
      return;
    end else if (raw == FLAG_BYTE) begin
      if (rx_in_frame) begin
        judge_frame();
      end else begin
        rx_in_frame = 1'b1;
        rx_count    = '0;
      end
      return;
    end
    if (!rx_in_frame) begin
      return;
    end
    if (rx_count == 0) begin
      rx_addr = b;
    end else if (rx_count == 1) begin
      rx_cmd = b;
    end else if (rx_count < INFO_BYTES + 2) begin
      rx_payload[rx_count - 2] = b;
    end else if (rx_count == INFO_BYTES + 2) begin
      rx_check_lo = b;
    end else if (rx_count == INFO_BYTES + 3) begin
      rx_check_hi = b;
    end
    if (rx_count < INFO_BYTES + 2) begin
      rx_crc = crc_step(rx_crc, b);
    end
    if (rx_count < COUNT_CAP) begin
      rx_count = rx_count + 1'b1;
    end
  endfunction

  // Offers one byte, with a random gap in front unless the steady stretch is on,
  // and returns at the edge that accepts the request.
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{rx_byte: b};
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    link_bytes_sent++;
    absorb_link_byte(b);
  endtask

  // Builds one frame around frame_payload, stuffs it and sends it between two flags.
  // Flag and escape values are always escaped; esc_pct escapes other bytes too.
  task automatic send_frame(input frame_kind_t kind, input int extent,
                            input logic [7:0] addr, input logic [7:0] cmd,
                            input int esc_pct);
    logic [7:0]  body [$];
    logic [15:0] fcs;
    int          k;
    bit          esc_it;
    if (kind == FR_NOISE) begin
      send_byte(ESC_BYTE);
      send_byte(FLAG_BYTE);
      send_byte(addr);
      send_byte(cmd);
    end else begin
      body.push_back(addr);
      body.push_back(cmd);
      for (k = 0; k < INFO_BYTES; k++) begin
        body.push_back(frame_payload[k]);
      end
      fcs = CRC_INIT;
      for (k = 0; k < body.size(); k++) begin
        fcs = crc_step(fcs, body[k]);
      end
      fcs = fcs ^ CRC_XOROUT;
      if (kind == FR_BAD_CHECK) begin
        fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
      end
      body.push_back(fcs[7:0]);
      body.push_back(fcs[15:8]);
      if (kind == FR_SHORT) begin
        while (body.size() > extent) begin
          void'(body.pop_back());
        end
      end else if (kind == FR_LONG) begin
        repeat (extent) begin
          body.push_back(8'($urandom_range(0, 255)));
        end
      end
      send_byte(FLAG_BYTE);
      for (k = 0; k < body.size(); k++) begin
        esc_it = (body[k] == FLAG_BYTE) || (body[k] == ESC_BYTE);
        if (esc_it || $urandom_range(1, 100) <= esc_pct) begin
          send_byte(ESC_BYTE);
          send_byte(body[k] ^ ESC_XOR);
        end else begin
          send_byte(body[k]);
        end
      end
      send_byte(FLAG_BYTE);
    end
  endtask

  // Closes whatever the stimulus left open, then waits until the block is idle.
  task automatic settle_phase();
    if (rx_escape) begin
      send_byte(8'h00);
    end
    if (rx_in_frame) begin
      send_byte(FLAG_BYTE);
    end
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; only called while idle.
  task automatic apply_settings(input logic [7:0] addr, input logic [7:0] code_a,
                                input logic [7:0] code_b);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_EXPECTED_ADDRESS;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_idx   <= CFG_COMMAND_CODE_A;
    cfg_wdata <= code_a;
    @(posedge clk);
    cfg_idx   <= CFG_COMMAND_CODE_B;
    cfg_wdata <= code_b;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_exp_addr = addr;
    cfg_code_a   = code_a;
    cfg_code_b   = code_b;
  endtask

  // Mostly well-formed frames with random content that match the current settings,
  // mixed with wrong addresses and commands, bad checks, cut and overlong frames and
  // loose bytes between frames.
  task automatic random_traffic(input int budget);
    int         start;
    int         pick;
    int         n;
    int         esc_pct;
    logic [7:0] addr;
    logic [7:0] cmd;
    start = link_bytes_sent;
    while (link_bytes_sent - start < budget) begin
      for (int k = 0; k < INFO_BYTES; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          frame_payload[k] = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
        end else begin
          frame_payload[k] = 8'($urandom_range(0, 255));
        end
      end
      addr = ($urandom_range(0, 99) < 85) ? cfg_exp_addr : 8'($urandom_range(0, 255));
      n = $urandom_range(0, 99);
      cmd = (n < 45) ? cfg_code_a : (n < 90) ? cfg_code_b : 8'($urandom_range(0, 255));
      esc_pct = ($urandom_range(0, 3) == 0) ? 25 : 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(FR_GOOD, 0, addr, cmd, esc_pct);
      end else if (pick < 70) begin
        send_frame(FR_BAD_CHECK, 0, addr, cmd, esc_pct);
      end else if (pick < 78) begin
        send_frame(FR_SHORT, $urandom_range(0, FRAME_LEN - 1), addr, cmd, esc_pct);
      end else if (pick < 86) begin
        send_frame(FR_LONG, $urandom_range(1, 6), addr, cmd, esc_pct);
      end else begin
        // Loose bytes; a stray flag here opens a frame that the next flag closes.
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 99) < 30) begin
            send_byte($urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE);
          end else begin
            send_byte(8'($urandom_range(0, 255)));
          end
        end
      end
    end
  endtask

  function automatic void field_check(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%02h, got 0x%02h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: every accepted result is held against the oldest expectation.
  // The same block counts the cycles without any accepted request for the watchdog.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got payload 0x%02h status %0d",
                   $time, out_ch.data.payload_byte, out_ch.data.frame_status);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          field_check("payload_byte", want.payload_byte, out_ch.data.payload_byte);
          field_check("frame_address", want.frame_address, out_ch.data.frame_address);
          field_check("frame_command", want.frame_command, out_ch.data.frame_command);
          field_check("frame_status", 8'(want.frame_status), 8'(out_ch.data.frame_status));
          field_check("last_of_run", 8'(want.last_of_run), 8'(out_ch.data.last_of_run));
        end
      end
    end
  end

  // Receiver side: ready drops at random, never during the steady stretch, and on
  // each toggle of hold_token it is held low so that the block backs up and stalls
  // its input at the next closing flag.
  initial begin : receiver_side
    bit hold_seen;
    hold_seen    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    @(posedge rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
    end
    $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] code;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_EXPECTED_ADDRESS;
    cfg_wdata       = 8'h00;
    in_ch.valid     = 1'b0;
    in_ch.data      = '0;
    steady          = 1'b0;
    hold_token      = 1'b0;
    typed_due       = 1'b0;
    typed_result    = '0;
    link_bytes_sent = 0;
    mismatches      = 0;
    cfg_exp_addr    = ADDR_RESET;
    cfg_code_a      = CODE_A_RESET;
    cfg_code_b      = CODE_B_RESET;
    rearm_deframer();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under the reset configuration.
    for (int r = 0; r < $size(plan); r++) begin
      for (int k = 0; k < INFO_BYTES; k++) begin
        frame_payload[k] = 8'(plan[r].fill + k * plan[r].step);
      end
      typed_due    = plan[r].typed;
      typed_result = plan[r].want;
      send_frame(plan[r].kind, plan[r].extent, plan[r].addr, plan[r].cmd, plan[r].esc_pct);
    end
    random_traffic(PHASE_BYTES);
    settle_phase();

    // Extreme register values, run as one stretch without any idling on either side.
    steady <= 1'b1;
    apply_settings(8'hFF, 8'h00, 8'hFF);
    random_traffic(PHASE_BYTES);
    settle_phase();
    steady <= 1'b0;

    // Random settings while the receiver holds off for a long stretch. Two empty
    // frames come first: the first status fills the output register and the second
    // closing flag has to wait, so the input stalls.
    apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    hold_token <= ~hold_token;
    send_frame(FR_SHORT, 0, 8'h00, 8'h00, 0);
    send_frame(FR_SHORT, 0, 8'h00, 8'h00, 0);
    random_traffic(PHASE_BYTES);
    settle_phase();

    // Flag value as the address, and both command codes the same.
    code = 8'($urandom_range(0, 255));
    apply_settings(FLAG_BYTE, code, code);
    random_traffic(PHASE_BYTES);
    settle_phase();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
